/* src/afl_pkg.sv */
// shared constants, event codes and the set hash for the allocation/free matcher
`default_nettype none

package afl_pkg;

   // field widths fixed by the event format
   localparam int KIND_WIDTH  = 2;
   localparam int ID_WIDTH    = 64;
   localparam int TYPE_WIDTH  = 6;
   localparam int INDEX_WIDTH = 32;
   localparam int MASK_WIDTH  = 32;

   // default table geometry
   localparam int SETS_DEFAULT       = 1024;
   localparam int WAYS_DEFAULT       = 4;
   localparam int COUNT_BITS_DEFAULT = 16;

   // event kind codes
   localparam logic [KIND_WIDTH-1:0] KIND_ALLOC = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_FREE  = 2'd2;

   // highest type number covered by the reference-count mask
   localparam logic [TYPE_WIDTH-1:0] TYPE_MAX_COUNTED = 6'(MASK_WIDTH);

   // hash fold: 16-bit windows stepped by 3 bits
   localparam int FOLD_BITS  = 16;
   localparam int FOLD_SHIFT = 3;
   localparam logic [FOLD_BITS-1:0] FOLD_MASK = 16'((1 << 16) - 1);
   localparam int ID_FOLD_STEPS   = (ID_WIDTH + FOLD_SHIFT - 1) / FOLD_SHIFT;
   localparam int TYPE_FOLD_STEPS = (TYPE_WIDTH + FOLD_SHIFT - 1) / FOLD_SHIFT;

   // xor of all shifted windows of id and type; windows past the top are zero
   function automatic logic [FOLD_BITS-1:0] fold_key(input logic [ID_WIDTH-1:0] id,
                                                     input logic [TYPE_WIDTH-1:0] rtype);
      logic [FOLD_BITS-1:0] h;
      h = '0;
      for (int k = 0; k < ID_FOLD_STEPS; k++) begin
         h = h ^ (FOLD_BITS'(id >> (FOLD_SHIFT * k)) & FOLD_MASK);
      end
      for (int k = 0; k < TYPE_FOLD_STEPS; k++) begin
         h = h ^ (FOLD_BITS'(rtype >> (FOLD_SHIFT * k)) & FOLD_MASK);
      end
      return h;
   endfunction

endpackage

`default_nettype wire

/* src/alloc_free_leak_matcher.sv */
// top level: live-resource table with hashed set lookup and a sequential way scan
// a new event is taken only in idle, after the previous event's result has been loaded into the result register
// the way scan uses one key comparator per cycle
// the set index comes from a reciprocal multiply and one correcting subtract in the MUL, SCALE and REDUCE states
// reset: a clearing pass writes all SETS rows, one row a cycle, with req_ready low
// the result register lets the next event in while a result waits to be taken
`default_nettype none

module alloc_free_leak_matcher #(
   parameter int SETS       = afl_pkg::SETS_DEFAULT,
   parameter int WAYS       = afl_pkg::WAYS_DEFAULT,
   parameter int COUNT_BITS = afl_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // configuration write channel
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [afl_pkg::MASK_WIDTH-1:0]  csr_refcount_type_mask,
   // event channel
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [afl_pkg::KIND_WIDTH-1:0]  req_kind,
   input  wire logic [afl_pkg::ID_WIDTH-1:0]    req_resource_id,
   input  wire logic [afl_pkg::TYPE_WIDTH-1:0]  req_resource_type,
   input  wire logic [afl_pkg::INDEX_WIDTH-1:0] req_event_index,
   // result channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_drop_current,
   output logic                                 rsp_drop_alloc,
   output logic [afl_pkg::INDEX_WIDTH-1:0]      rsp_alloc_event_index,
   output logic                                 rsp_table_full
);

   localparam int SET_BITS  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RECIP_BITS = 33;
   localparam int PROD_BITS  = afl_pkg::FOLD_BITS + RECIP_BITS;
   localparam int REM_BITS   = afl_pkg::FOLD_BITS + 1;
   localparam logic [RECIP_BITS-1:0] RECIP =
      RECIP_BITS'(((64'd1 << 32) + 64'(SETS) - 64'd1) / 64'(SETS));
   localparam logic [REM_BITS-1:0]   SETS_REM  = REM_BITS'(SETS);
   localparam logic [SET_BITS-1:0]   LAST_SET  = SET_BITS'(SETS - 1);
   localparam logic [WAY_BITS-1:0]   LAST_WAY  = WAY_BITS'(WAYS - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   typedef struct packed {
      logic                              valid;
      logic [afl_pkg::ID_WIDTH-1:0]      key_id;
      logic [afl_pkg::TYPE_WIDTH-1:0]    key_type;
      logic [afl_pkg::INDEX_WIDTH-1:0]   alloc_index;
      logic [COUNT_BITS-1:0]             count;
   } entry_type;

   typedef entry_type [WAYS-1:0] row_type;

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_MUL    = 8'b0000_0100,
      ST_SCALE  = 8'b0000_1000,
      ST_REDUCE = 8'b0001_0000,
      ST_READ   = 8'b0010_0000,
      ST_SCAN   = 8'b0100_0000,
      ST_UPDATE = 8'b1000_0000
   } state_type;

   // control registers
   state_type                        state_ff, state_in;
   logic [SET_BITS-1:0]              clear_ptr_ff, clear_ptr_in;
   logic [WAY_BITS-1:0]              way_ff, way_in;
   logic                             hit_ff, hit_in;
   logic [WAY_BITS-1:0]              hit_way_ff, hit_way_in;
   logic                             free_found_ff, free_found_in;
   logic [WAY_BITS-1:0]              free_way_ff, free_way_in;
   logic [afl_pkg::MASK_WIDTH-1:0]   mask_ff, mask_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   // event and datapath registers
   logic [afl_pkg::KIND_WIDTH-1:0]   kind_ff, kind_in;
   logic [afl_pkg::ID_WIDTH-1:0]     id_ff, id_in;
   logic [afl_pkg::TYPE_WIDTH-1:0]   type_ff, type_in;
   logic [afl_pkg::INDEX_WIDTH-1:0]  evidx_ff, evidx_in;
   logic [afl_pkg::FOLD_BITS-1:0]    hash_ff, hash_in;
   logic [PROD_BITS-1:0]             prod_ff, prod_in;
   logic [REM_BITS-1:0]              scaled_ff, scaled_in;
   logic [SET_BITS-1:0]              set_ff, set_in;
   logic                             rsp_drop_current_ff, rsp_drop_current_in;
   logic                             rsp_drop_alloc_ff, rsp_drop_alloc_in;
   logic [afl_pkg::INDEX_WIDTH-1:0]  rsp_alloc_index_ff, rsp_alloc_index_in;
   logic                             rsp_table_full_ff, rsp_table_full_in;

   // row memory
   row_type                          row_mem [SETS];
   row_type                          row_rd_ff;
   logic                             mem_re;
   logic                             mem_we;
   logic [SET_BITS-1:0]              mem_waddr;
   row_type                          mem_wdata;

   // combinational helpers
   logic                             req_xfer;
   logic                             advance;
   entry_type                        cur_entry;
   entry_type                        hit_entry;
   entry_type                        new_entry;
   logic                             key_match;
   logic                             counted;
   logic [afl_pkg::TYPE_WIDTH-1:0]   type_dec;
   logic [afl_pkg::FOLD_BITS-1:0]    quot;
   logic [REM_BITS-1:0]              rem;
   logic [REM_BITS-1:0]              rem_adj;
   logic [COUNT_BITS-1:0]            count_dec;
   logic [WAY_BITS-1:0]              wr_way;
   logic                             upd_we;
   logic                             res_drop_current;
   logic                             res_drop_alloc;
   logic [afl_pkg::INDEX_WIDTH-1:0]  res_alloc_index;
   logic                             res_table_full;
   row_type                          row_wr;

   assign csr_ready             = 1'b1;
   assign req_ready             = (state_ff == ST_IDLE);
   assign req_xfer              = req_valid && req_ready;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_drop_current      = rsp_drop_current_ff;
   assign rsp_drop_alloc        = rsp_drop_alloc_ff;
   assign rsp_alloc_event_index = rsp_alloc_index_ff;
   assign rsp_table_full        = rsp_table_full_ff;

   // update may only retire when the result register is free
   assign advance = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);

   // set index arithmetic: h mod SETS by reciprocal multiply
   assign quot    = prod_ff[32 +: afl_pkg::FOLD_BITS];
   assign rem     = {1'b0, hash_ff} - scaled_ff;
   assign rem_adj = (rem >= SETS_REM) ? (rem - SETS_REM) : rem;

   // shared key comparator, one way per cycle
   assign cur_entry = row_rd_ff[way_ff];
   assign key_match = cur_entry.valid && (cur_entry.key_id == id_ff) &&
                      (cur_entry.key_type == type_ff);

   // reference-counted type lookup
   assign type_dec = type_ff - 6'd1;
   assign counted  = (type_ff != '0) && (type_ff <= afl_pkg::TYPE_MAX_COUNTED) &&
                     mask_ff[type_dec[4:0]];

   // entry update and result for the scanned set
   always_comb begin
      hit_entry        = row_rd_ff[hit_way_ff];
      new_entry        = hit_entry;
      wr_way           = hit_way_ff;
      upd_we           = 1'b0;
      res_drop_current = 1'b0;
      res_drop_alloc   = 1'b0;
      res_alloc_index  = '0;
      res_table_full   = 1'b0;
      count_dec        = (hit_entry.count != '0) ? (hit_entry.count - COUNT_ONE)
                                                 : hit_entry.count;
      if (kind_ff == afl_pkg::KIND_ALLOC) begin
         if (hit_ff && counted) begin
            // repeated allocation of a counted resource
            if (hit_entry.count != COUNT_MAX) begin
               new_entry.count = hit_entry.count + COUNT_ONE;
            end
            upd_we           = 1'b1;
            res_drop_current = 1'b1;
         end else if (!hit_ff && !free_found_ff) begin
            res_table_full = 1'b1;
         end else begin
            // store new entry or replace the matching one
            wr_way                = hit_ff ? hit_way_ff : free_way_ff;
            new_entry.valid       = 1'b1;
            new_entry.key_id      = id_ff;
            new_entry.key_type    = type_ff;
            new_entry.alloc_index = evidx_ff;
            new_entry.count       = COUNT_ONE;
            upd_we                = 1'b1;
         end
      end else if (kind_ff == afl_pkg::KIND_FREE) begin
         res_drop_current = 1'b1;
         if (hit_ff) begin
            new_entry.count = count_dec;
            upd_we          = 1'b1;
            if ((count_dec == '0) || !counted) begin
               new_entry.valid = 1'b0;
               res_drop_alloc  = 1'b1;
               res_alloc_index = hit_entry.alloc_index;
            end
         end
      end
      row_wr         = row_rd_ff;
      row_wr[wr_way] = new_entry;
   end

   // memory port control
   always_comb begin
      mem_re    = (state_ff == ST_READ);
      mem_we    = 1'b0;
      mem_waddr = set_ff;
      mem_wdata = row_wr;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clear_ptr_ff;
         mem_wdata = '0;
      end else if (advance) begin
         mem_we = upd_we;
      end
   end

   // sequencer
   always_comb begin
      state_in            = state_ff;
      clear_ptr_in        = clear_ptr_ff;
      way_in              = way_ff;
      hit_in              = hit_ff;
      hit_way_in          = hit_way_ff;
      free_found_in       = free_found_ff;
      free_way_in         = free_way_ff;
      mask_in             = mask_ff;
      rsp_valid_in        = rsp_valid_ff;
      kind_in             = kind_ff;
      id_in               = id_ff;
      type_in             = type_ff;
      evidx_in            = evidx_ff;
      hash_in             = hash_ff;
      prod_in             = prod_ff;
      scaled_in           = scaled_ff;
      set_in              = set_ff;
      rsp_drop_current_in = rsp_drop_current_ff;
      rsp_drop_alloc_in   = rsp_drop_alloc_ff;
      rsp_alloc_index_in  = rsp_alloc_index_ff;
      rsp_table_full_in   = rsp_table_full_ff;

      // configuration transfer
      if (csr_valid && csr_ready) begin
         mask_in = csr_refcount_type_mask;
      end

      // result register drains
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clear_ptr_in = clear_ptr_ff + SET_BITS'(1);
            if (clear_ptr_ff == LAST_SET) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               kind_in  = req_kind;
               id_in    = req_resource_id;
               type_in  = req_resource_type;
               evidx_in = req_event_index;
               hash_in  = afl_pkg::fold_key(req_resource_id, req_resource_type);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_BITS'(hash_ff) * PROD_BITS'(RECIP);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            scaled_in = REM_BITS'(RECIP_BITS'(quot) * RECIP_BITS'(SETS));
            state_in  = ST_REDUCE;
         end
         ST_REDUCE: begin
            set_in   = SET_BITS'(rem_adj);
            state_in = ST_READ;
         end
         ST_READ: begin
            way_in        = '0;
            hit_in        = 1'b0;
            hit_way_in    = '0;
            free_found_in = 1'b0;
            free_way_in   = '0;
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            // first match wins, lowest invalid way is the free slot
            if (cur_entry.valid) begin
               if (!hit_ff && key_match) begin
                  hit_in     = 1'b1;
                  hit_way_in = way_ff;
               end
            end else if (!free_found_ff) begin
               free_found_in = 1'b1;
               free_way_in   = way_ff;
            end
            if (way_ff == LAST_WAY) begin
               state_in = ST_UPDATE;
            end else begin
               way_in = way_ff + WAY_BITS'(1);
            end
         end
         ST_UPDATE: begin
            if (advance) begin
               rsp_valid_in        = 1'b1;
               rsp_drop_current_in = res_drop_current;
               rsp_drop_alloc_in   = res_drop_alloc;
               rsp_alloc_index_in  = res_alloc_index;
               rsp_table_full_in   = res_table_full;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_ptr_ff  <= '0;
         way_ff        <= '0;
         hit_ff        <= 1'b0;
         hit_way_ff    <= '0;
         free_found_ff <= 1'b0;
         free_way_ff   <= '0;
         mask_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_ptr_ff  <= clear_ptr_in;
         way_ff        <= way_in;
         hit_ff        <= hit_in;
         hit_way_ff    <= hit_way_in;
         free_found_ff <= free_found_in;
         free_way_ff   <= free_way_in;
         mask_ff       <= mask_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff             <= kind_in;
      id_ff               <= id_in;
      type_ff             <= type_in;
      evidx_ff            <= evidx_in;
      hash_ff             <= hash_in;
      prod_ff             <= prod_in;
      scaled_ff           <= scaled_in;
      set_ff              <= set_in;
      rsp_drop_current_ff <= rsp_drop_current_in;
      rsp_drop_alloc_ff   <= rsp_drop_alloc_in;
      rsp_alloc_index_ff  <= rsp_alloc_index_in;
      rsp_table_full_ff   <= rsp_table_full_in;
   end

   // set memory: one row write, one registered row read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         row_rd_ff <= row_mem[set_ff];
      end
   end

   // checks
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("event accepted during clearing pass");

   a_full_not_dropped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_table_full && (rsp_drop_current || rsp_drop_alloc)))
      else $error("full set result also reports a drop");

   a_alloc_drop_with_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_drop_alloc) |-> rsp_drop_current)
      else $error("earlier allocation dropped without dropping the free");

   a_write_only_clear_or_update: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == ST_CLEAR) || (state_ff == ST_UPDATE)))
      else $error("set memory written outside clear or update");

   a_accept_starts_hash: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_MUL))
      else $error("accepted event did not start set index computation");

endmodule

`default_nettype wire
